[design/ddpid_pkg.sv]
// Package for the differential-drive PID loop: widths, fixed-point constants,
// register indexes and reset values, and the 48-bit saturation helper.
// Depends on nothing; imported by differential_drive_pid_loop.
package ddpid_pkg;

   // Encoder counter width and the wheel delta arithmetic derived from it.
   localparam int COUNTER_BITS = 16;
   localparam int CNT_W        = COUNTER_BITS;
   localparam int DELTA_W      = CNT_W + 2;
   localparam logic signed [DELTA_W-1:0] WRAP_MOD    = DELTA_W'(1) << CNT_W;
   localparam logic signed [DELTA_W-1:0] WRAP_THRESH = WRAP_MOD - (WRAP_MOD >>> 4);

   // Port field widths.
   localparam int IN_COUNT_W  = 16;
   localparam int TARGET_W    = 32;
   localparam int DRIVE_W     = 16;

   // Datapath widths.
   localparam int GAIN_W  = 16;
   localparam int ACC_W   = 48;
   localparam int OPND_W  = 50;
   localparam int HALF_W  = OPND_W / 2;
   localparam int PP_W    = GAIN_W + HALF_W;
   localparam int PROD_W  = GAIN_W + OPND_W;
   localparam int SUM_W   = 64;
   localparam int QSHIFT  = 24;
   localparam int CTRL_W  = SUM_W - QSHIFT;

   // Each gain product is clamped to +-2^61.
   localparam logic [PROD_W-1:0] TERM_LIM  = PROD_W'(1) << 61;
   // 16777 / 2^24 is the integration step of about 0.001.
   localparam logic [GAIN_W-1:0] ISTEP_Q24 = 16'd16777;
   localparam logic [SUM_W-1:0]  Q24_BIAS  = (SUM_W'(1) << QSHIFT) - SUM_W'(1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_PROP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_DERIV  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_INTEG  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_PROP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_DERIV = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_SCALE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_SCALE = 3'd6;

   // Register reset values.
   localparam logic [GAIN_W-1:0] RST_DIST_PROP   = 16'd3840;
   localparam logic [GAIN_W-1:0] RST_DIST_DERIV  = 16'd0;
   localparam logic [GAIN_W-1:0] RST_DIST_INTEG  = 16'd256;
   localparam logic [GAIN_W-1:0] RST_ANGLE_PROP  = 16'd12800;
   localparam logic [GAIN_W-1:0] RST_ANGLE_DERIV = 16'd0;
   localparam logic [GAIN_W-1:0] RST_DIST_SCALE  = 16'd65535;
   localparam logic [GAIN_W-1:0] RST_ANGLE_SCALE = 16'd65535;

   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [OPND_W-1:0] opnd_type;

   // Saturate an operand-width value to the 48-bit signed accumulator range.
   function automatic acc_type sat_acc(input opnd_type v);
      logic [OPND_W-ACC_W:0] top;
      top = v[OPND_W-1:ACC_W-1];
      if ((top == '0) || (top == '1)) begin
         sat_acc = v[ACC_W-1:0];
      end else if (v[OPND_W-1]) begin
         sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
      end
   endfunction

endpackage

[design/differential_drive_pid_loop.sv]
// Top level of the differential-drive PID position and heading controller.
// Holds the sequencer, the shared multiplier datapath and the registers.
// Depends on ddpid_pkg.

// Each request transaction carries one control tick: the raw left and right
// encoder counter readings and the position and angle targets. The block forms
// wrapped wheel deltas against the previous readings, turns their half sum and
// half difference into forward and rotational feedback, scales them into
// accumulated position and heading, runs a PID on the position error and a PD
// on the heading error, and returns one response transaction with the left and
// right drive values (forward plus and minus rotation, saturated to 16 bits).
// All arithmetic products go through one shared 16 x 25 bit multiplier under a
// small sequencer; eight products are needed per tick (two feedback scalings,
// the integration step and five gain terms), each passing through the setup
// state, the multiplier states MUL0 to MUL2 and the accumulate state. The
// block takes no new request until the current one has been worked through
// and its response written to the output register. req_ready is high only
// between ticks; a finished response sits in an output register, so the next
// request can be taken while the previous response still waits. The gain and
// scale registers on the csr_ port must be written only while the block is idle.
module differential_drive_pid_loop (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ddpid_pkg::IN_COUNT_W-1:0]       req_left_count,
   input  logic [ddpid_pkg::IN_COUNT_W-1:0]       req_right_count,
   input  logic signed [ddpid_pkg::TARGET_W-1:0]  req_target_position,
   input  logic signed [ddpid_pkg::TARGET_W-1:0]  req_target_angle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ddpid_pkg::DRIVE_W-1:0]   rsp_left_drive,
   output logic signed [ddpid_pkg::DRIVE_W-1:0]   rsp_right_drive,
   input  logic                                   csr_wr_en,
   input  logic [ddpid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ddpid_pkg::GAIN_W-1:0]           csr_wdata
);
   import ddpid_pkg::*;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FB     = 4'd1;
   localparam logic [3:0] ST_SETUP  = 4'd2;
   localparam logic [3:0] ST_MUL0   = 4'd3;
   localparam logic [3:0] ST_MUL1   = 4'd4;
   localparam logic [3:0] ST_MUL2   = 4'd5;
   localparam logic [3:0] ST_APPLY  = 4'd6;
   localparam logic [3:0] ST_ERRX   = 4'd7;
   localparam logic [3:0] ST_ERRW   = 4'd8;
   localparam logic [3:0] ST_FWD    = 4'd9;
   localparam logic [3:0] ST_ROT    = 4'd10;
   localparam logic [3:0] ST_FINISH = 4'd11;

   // Product operations, in the order the sequencer runs them.
   localparam logic [2:0] OP_POS   = 3'd0;  // forward feedback times distance scale
   localparam logic [2:0] OP_HEAD  = 3'd1;  // rotational feedback times angle scale
   localparam logic [2:0] OP_INTEG = 3'd2;  // position error times integration step
   localparam logic [2:0] OP_DPROP = 3'd3;  // position proportional term
   localparam logic [2:0] OP_DDER  = 3'd4;  // position derivative term
   localparam logic [2:0] OP_DINT  = 3'd5;  // position integral term
   localparam logic [2:0] OP_APROP = 3'd6;  // heading proportional term
   localparam logic [2:0] OP_ADER  = 3'd7;  // heading derivative term

   // Wrapped difference of two counter readings.
   function automatic logic signed [DELTA_W-1:0] wrap_delta(input logic [CNT_W-1:0] cur,
                                                            input logic [CNT_W-1:0] prev);
      logic signed [DELTA_W-1:0] d;
      d = $signed({2'b00, cur}) - $signed({2'b00, prev});
      if (d > WRAP_THRESH) begin
         wrap_delta = d - WRAP_MOD;
      end else if (d < -WRAP_THRESH) begin
         wrap_delta = d + WRAP_MOD;
      end else begin
         wrap_delta = d;
      end
   endfunction

   // Halve with truncation toward zero.
   function automatic logic signed [DELTA_W-1:0] half_tz(input logic signed [DELTA_W:0] s);
      logic signed [DELTA_W:0] t;
      t = s + $signed({{DELTA_W{1'b0}}, s[DELTA_W]});
      half_tz = t[DELTA_W:1];
   endfunction

   // Divide by 2^24 with truncation toward zero.
   function automatic logic signed [CTRL_W-1:0] div_q24(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-1:0] t;
      t = s[SUM_W-1] ? (s + Q24_BIAS) : s;
      div_q24 = t[SUM_W-1:QSHIFT];
   endfunction

   // Saturate a control sum to the drive range.
   function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [CTRL_W:0] v);
      logic [CTRL_W-DRIVE_W+1:0] top;
      top = v[CTRL_W:DRIVE_W-1];
      if ((top == '0) || (top == '1)) begin
         sat_drive = v[DRIVE_W-1:0];
      end else if (v[CTRL_W]) begin
         sat_drive = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         sat_drive = {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   endfunction

   function automatic opnd_type ext_acc(input acc_type v);
      ext_acc = {{(OPND_W-ACC_W){v[ACC_W-1]}}, v};
   endfunction

   // Control and architectural state.
   logic [3:0]          state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0]   dprop_ff, dprop_in;
   logic [GAIN_W-1:0]   dder_ff, dder_in;
   logic [GAIN_W-1:0]   dint_ff, dint_in;
   logic [GAIN_W-1:0]   aprop_ff, aprop_in;
   logic [GAIN_W-1:0]   ader_ff, ader_in;
   logic [GAIN_W-1:0]   dscale_ff, dscale_in;
   logic [GAIN_W-1:0]   ascale_ff, ascale_in;
   logic [CNT_W-1:0]    prev_left_ff, prev_left_in;
   logic [CNT_W-1:0]    prev_right_ff, prev_right_in;
   acc_type             position_ff, position_in;
   acc_type             heading_ff, heading_in;
   acc_type             integ_ff, integ_in;
   acc_type             last_derr_ff, last_derr_in;
   acc_type             last_aerr_ff, last_aerr_in;

   // Working registers of one tick.
   logic signed [DELTA_W-1:0] dl_ff, dl_in;
   logic signed [DELTA_W-1:0] dr_ff, dr_in;
   logic signed [DELTA_W-1:0] fbx_ff, fbx_in;
   logic signed [DELTA_W-1:0] fbw_ff, fbw_in;
   logic signed [TARGET_W-1:0] tpos_ff, tpos_in;
   logic signed [TARGET_W-1:0] tang_ff, tang_in;
   acc_type             err_x_ff, err_x_in;
   acc_type             err_w_ff, err_w_in;
   logic [OPND_W-1:0]   mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [PP_W-1:0]     pp_ff, pp_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [CTRL_W-1:0] fwd_ff, fwd_in;
   logic signed [CTRL_W-1:0] rot_ff, rot_in;
   logic signed [DRIVE_W-1:0] left_ff, left_in;
   logic signed [DRIVE_W-1:0] right_ff, right_in;

   // Combinational datapath.
   logic                req_fire;
   logic [CNT_W-1:0]    cur_left, cur_right;
   opnd_type            opa, opb, diff_ab, diff_ba;
   logic [GAIN_W-1:0]   op_gain;
   logic [HALF_W-1:0]   mul_b;
   logic [PP_W-1:0]     mul_out;
   logic [PROD_W-1:0]   prod_shift;
   opnd_type            acc_base, acc_addend, acc_sum;
   logic signed [SUM_W-1:0] term_mag;
   opnd_type            tgt_diff;
   logic signed [CTRL_W:0]  left_sum, right_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;

   assign cur_left  = CNT_W'(req_left_count);
   assign cur_right = CNT_W'(req_right_count);

   // Operand selection for the shared multiplier. The derivative terms take the
   // difference of two errors; both subtraction orders are formed so that the
   // magnitude comes out of a single adder level.
   always_comb begin
      opa     = ext_acc(err_x_ff);
      opb     = '0;
      op_gain = dprop_ff;
      case (op_ff)
         OP_POS: begin
            opa     = {{(OPND_W-DELTA_W){fbx_ff[DELTA_W-1]}}, fbx_ff};
            op_gain = dscale_ff;
         end
         OP_HEAD: begin
            opa     = {{(OPND_W-DELTA_W){fbw_ff[DELTA_W-1]}}, fbw_ff};
            op_gain = ascale_ff;
         end
         OP_INTEG: begin
            op_gain = ISTEP_Q24;
         end
         OP_DPROP: begin
            op_gain = dprop_ff;
         end
         OP_DDER: begin
            opb     = ext_acc(last_derr_ff);
            op_gain = dder_ff;
         end
         OP_DINT: begin
            opa     = ext_acc(integ_ff);
            op_gain = dint_ff;
         end
         OP_APROP: begin
            opa     = ext_acc(err_w_ff);
            op_gain = aprop_ff;
         end
         OP_ADER: begin
            opa     = ext_acc(err_w_ff);
            opb     = ext_acc(last_aerr_ff);
            op_gain = ader_ff;
         end
         default: begin
            op_gain = dprop_ff;
         end
      endcase
   end

   assign diff_ab = opa - opb;
   assign diff_ba = opb - opa;

   // The one multiplier: gain times the low or the high half of the magnitude.
   assign mul_b      = (state_ff == ST_MUL0) ? mag_ff[HALF_W-1:0] : mag_ff[OPND_W-1:HALF_W];
   assign mul_out    = PP_W'(gain_ff) * PP_W'(mul_b);
   assign prod_shift = PROD_W'(pp_ff) << HALF_W;

   // Accumulate step for position, heading and the integral.
   always_comb begin
      case (op_ff)
         OP_POS: begin
            acc_base   = ext_acc(position_ff);
            acc_addend = {1'b0, prod_ff[OPND_W-2:0]};
         end
         OP_HEAD: begin
            acc_base   = ext_acc(heading_ff);
            acc_addend = {1'b0, prod_ff[OPND_W-2:0]};
         end
         default: begin
            acc_base   = ext_acc(integ_ff);
            acc_addend = {{(OPND_W-PROD_W+QSHIFT){1'b0}}, prod_ff[PROD_W-1:QSHIFT]};
         end
      endcase
   end

   assign acc_sum  = neg_ff ? (acc_base - acc_addend) : (acc_base + acc_addend);
   assign term_mag = (prod_ff > TERM_LIM) ? $signed(TERM_LIM[SUM_W-1:0])
                                          : $signed(prod_ff[SUM_W-1:0]);
   assign tgt_diff = (op_ff == OP_HEAD)
                   ? ({{(OPND_W-TARGET_W){tang_ff[TARGET_W-1]}}, tang_ff} - ext_acc(heading_ff))
                   : ({{(OPND_W-TARGET_W){tpos_ff[TARGET_W-1]}}, tpos_ff} - ext_acc(position_ff));
   assign left_sum  = {fwd_ff[CTRL_W-1], fwd_ff} + {rot_ff[CTRL_W-1], rot_ff};
   assign right_sum = {fwd_ff[CTRL_W-1], fwd_ff} - {rot_ff[CTRL_W-1], rot_ff};

   // Configuration writes; an index past the last register is ignored.
   always_comb begin
      dprop_in  = dprop_ff;
      dder_in   = dder_ff;
      dint_in   = dint_ff;
      aprop_in  = aprop_ff;
      ader_in   = ader_ff;
      dscale_in = dscale_ff;
      ascale_in = ascale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DIST_PROP:   dprop_in  = csr_wdata;
            CSR_DIST_DERIV:  dder_in   = csr_wdata;
            CSR_DIST_INTEG:  dint_in   = csr_wdata;
            CSR_ANGLE_PROP:  aprop_in  = csr_wdata;
            CSR_ANGLE_DERIV: ader_in   = csr_wdata;
            CSR_DIST_SCALE:  dscale_in = csr_wdata;
            CSR_ANGLE_SCALE: ascale_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer. After the operands of a tick are latched, the eight products
   // run in order; between them the position and heading errors are formed and
   // the forward term is taken out of the accumulator before the heading terms.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      position_in   = position_ff;
      heading_in    = heading_ff;
      integ_in      = integ_ff;
      last_derr_in  = last_derr_ff;
      last_aerr_in  = last_aerr_ff;
      dl_in         = dl_ff;
      dr_in         = dr_ff;
      fbx_in        = fbx_ff;
      fbw_in        = fbw_ff;
      tpos_in       = tpos_ff;
      tang_in       = tang_ff;
      err_x_in      = err_x_ff;
      err_w_in      = err_w_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      gain_in       = gain_ff;
      pp_in         = pp_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      fwd_in        = fwd_ff;
      rot_in        = rot_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               dl_in         = wrap_delta(cur_left, prev_left_ff);
               dr_in         = wrap_delta(cur_right, prev_right_ff);
               prev_left_in  = cur_left;
               prev_right_in = cur_right;
               tpos_in       = req_target_position;
               tang_in       = req_target_angle;
               op_in         = OP_POS;
               state_in      = ST_FB;
            end
         end
         ST_FB: begin
            fbx_in   = half_tz($signed({dl_ff[DELTA_W-1], dl_ff}) +
                               $signed({dr_ff[DELTA_W-1], dr_ff}));
            fbw_in   = half_tz($signed({dl_ff[DELTA_W-1], dl_ff}) -
                               $signed({dr_ff[DELTA_W-1], dr_ff}));
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            neg_in   = diff_ab[OPND_W-1];
            mag_in   = diff_ab[OPND_W-1] ? diff_ba : diff_ab;
            gain_in  = op_gain;
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            prod_in  = PROD_W'(mul_out);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            pp_in    = mul_out;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = prod_ff + prod_shift;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            op_in = op_ff + 3'd1;
            case (op_ff)
               OP_POS: begin
                  position_in = sat_acc(acc_sum);
                  state_in    = ST_SETUP;
               end
               OP_HEAD: begin
                  heading_in = sat_acc(acc_sum);
                  state_in   = ST_ERRX;
               end
               OP_INTEG: begin
                  integ_in = sat_acc(acc_sum);
                  state_in = ST_SETUP;
               end
               OP_DINT: begin
                  sum_in   = neg_ff ? (sum_ff - term_mag) : (sum_ff + term_mag);
                  state_in = ST_FWD;
               end
               OP_ADER: begin
                  sum_in   = neg_ff ? (sum_ff - term_mag) : (sum_ff + term_mag);
                  state_in = ST_ROT;
               end
               default: begin
                  sum_in   = neg_ff ? (sum_ff - term_mag) : (sum_ff + term_mag);
                  state_in = ST_SETUP;
               end
            endcase
         end
         ST_ERRX: begin
            // op_ff already points at the integral step, so the target mux
            // selects the position pair here.
            err_x_in = sat_acc(tgt_diff);
            state_in = ST_ERRW;
         end
         ST_ERRW: begin
            err_w_in = sat_acc({{(OPND_W-TARGET_W){tang_ff[TARGET_W-1]}}, tang_ff} -
                               ext_acc(heading_ff));
            sum_in   = '0;
            state_in = ST_SETUP;
         end
         ST_FWD: begin
            fwd_in   = div_q24(sum_ff);
            sum_in   = '0;
            state_in = ST_SETUP;
         end
         ST_ROT: begin
            rot_in       = div_q24(sum_ff);
            last_derr_in = err_x_ff;
            last_aerr_in = err_w_ff;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               left_in      = sat_drive(left_sum);
               right_in     = sat_drive(right_sum);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_POS;
         rsp_valid_ff  <= 1'b0;
         dprop_ff      <= RST_DIST_PROP;
         dder_ff       <= RST_DIST_DERIV;
         dint_ff       <= RST_DIST_INTEG;
         aprop_ff      <= RST_ANGLE_PROP;
         ader_ff       <= RST_ANGLE_DERIV;
         dscale_ff     <= RST_DIST_SCALE;
         ascale_ff     <= RST_ANGLE_SCALE;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         position_ff   <= '0;
         heading_ff    <= '0;
         integ_ff      <= '0;
         last_derr_ff  <= '0;
         last_aerr_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
         dprop_ff      <= dprop_in;
         dder_ff       <= dder_in;
         dint_ff       <= dint_in;
         aprop_ff      <= aprop_in;
         ader_ff       <= ader_in;
         dscale_ff     <= dscale_in;
         ascale_ff     <= ascale_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         position_ff   <= position_in;
         heading_ff    <= heading_in;
         integ_ff      <= integ_in;
         last_derr_ff  <= last_derr_in;
         last_aerr_ff  <= last_aerr_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff    <= dl_in;
      dr_ff    <= dr_in;
      fbx_ff   <= fbx_in;
      fbw_ff   <= fbw_in;
      tpos_ff  <= tpos_in;
      tang_ff  <= tang_in;
      err_x_ff <= err_x_in;
      err_w_ff <= err_w_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      gain_ff  <= gain_in;
      pp_ff    <= pp_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      fwd_ff   <= fwd_in;
      rot_ff   <= rot_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   // A response appears only out of the final mixing step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside the final mixing step");

   // The position accumulator moves only on its own accumulate step.
   a_position_update: assert property (@(posedge clock) disable iff (reset)
      (position_ff != $past(position_ff)) |->
         ($past(reset) || (($past(state_ff) == ST_APPLY) && ($past(op_ff) == OP_POS))))
      else $error("position changed outside its accumulate step");

   // The stored errors for the derivative terms change only at the end of a tick.
   a_last_error_update: assert property (@(posedge clock) disable iff (reset)
      ((last_derr_ff != $past(last_derr_ff)) || (last_aerr_ff != $past(last_aerr_ff))) |->
         ($past(reset) || ($past(state_ff) == ST_ROT)))
      else $error("previous errors changed before the tick finished");

endmodule

[tb/ddpid_drive_checker.sv]
`timescale 1ns / 100ps
// Drive checker for the differential-drive PID loop: a cycle-free predictor of the
// controller state and a queue of expected left and right drive values.
// Depends on ddpid_pkg for widths, register indexes and reset values.
module ddpid_drive_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [ddpid_pkg::IN_COUNT_W-1:0]       req_left_count,
   input  logic [ddpid_pkg::IN_COUNT_W-1:0]       req_right_count,
   input  logic signed [ddpid_pkg::TARGET_W-1:0]  req_target_position,
   input  logic signed [ddpid_pkg::TARGET_W-1:0]  req_target_angle,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [ddpid_pkg::DRIVE_W-1:0]   rsp_left_drive,
   input  logic signed [ddpid_pkg::DRIVE_W-1:0]   rsp_right_drive,
   input  logic                                   csr_wr_en,
   input  logic [ddpid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ddpid_pkg::GAIN_W-1:0]           csr_wdata,
   output int                                     fail_count,
   output int                                     outstanding,
   output int                                     ticks_checked
);
   import ddpid_pkg::*;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
   } drive_pair_type;

   localparam longint COUNT_SPAN  = 64'sd1 <<< COUNTER_BITS;
   localparam longint WRAP_LIMIT  = COUNT_SPAN - (COUNT_SPAN >>> 4);
   localparam longint ACC_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_MIN     = -ACC_MAX - 64'sd1;
   localparam longint PRODUCT_MAX = 64'sd1 <<< 61;
   localparam longint Q24_ONE     = 64'sd1 <<< QSHIFT;
   localparam longint DRIVE_MAX   = 64'sd32767;
   localparam longint DRIVE_MIN   = -64'sd32768;

   logic [GAIN_W-1:0] dist_kp, dist_kd, dist_ki, angle_kp, angle_kd;
   logic [GAIN_W-1:0] dist_scale, angle_scale;
   logic [IN_COUNT_W-1:0] prev_left, prev_right;
   longint position, heading, integral, last_dist_err, last_angle_err;

   drive_pair_type drive_queue[$];

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   function automatic longint clamp_drive(input longint v);
      if (v > DRIVE_MAX) return DRIVE_MAX;
      if (v < DRIVE_MIN) return DRIVE_MIN;
      return v;
   endfunction

   // Signed count change with the modulus correction near a full turn.
   function automatic longint wheel_step(input logic [IN_COUNT_W-1:0] raw,
                                         input logic [IN_COUNT_W-1:0] old);
      longint cur_count, old_count, d;
      cur_count = raw;
      cur_count = cur_count & (COUNT_SPAN - 1);
      old_count = old;
      d = cur_count - old_count;
      if (d > WRAP_LIMIT) begin
         d = d - COUNT_SPAN;
      end else if (d < -WRAP_LIMIT) begin
         d = d + COUNT_SPAN;
      end
      return d;
   endfunction

   function automatic longint gain_product(input logic [GAIN_W-1:0] g, input longint v);
      longint gl, mag;
      gl = g;
      if (gl == 0 || v == 0) return 0;
      mag = (v < 0) ? -v : v;
      if (mag > PRODUCT_MAX / gl) return (v < 0) ? -PRODUCT_MAX : PRODUCT_MAX;
      return gl * v;
   endfunction

   // Advances the controller by one tick and returns the drive pair it produces.
   function automatic drive_pair_type next_drive(input logic [IN_COUNT_W-1:0] left_raw,
                                                 input logic [IN_COUNT_W-1:0] right_raw,
                                                 input logic signed [TARGET_W-1:0] pos_goal,
                                                 input logic signed [TARGET_W-1:0] ang_goal);
      longint dl, dr, fwd_fb, rot_fb, dist_err, ang_err, fwd, rot, goal, scale;
      drive_pair_type res;
      dl = wheel_step(left_raw, prev_left);
      dr = wheel_step(right_raw, prev_right);
      prev_left  = IN_COUNT_W'(left_raw & IN_COUNT_W'(COUNT_SPAN - 1));
      prev_right = IN_COUNT_W'(right_raw & IN_COUNT_W'(COUNT_SPAN - 1));
      fwd_fb = (dl + dr) / 2;
      rot_fb = (dl - dr) / 2;

      scale = dist_scale;
      position = clamp_acc(position + fwd_fb * scale);
      scale = angle_scale;
      heading = clamp_acc(heading + rot_fb * scale);

      goal = pos_goal;
      dist_err = clamp_acc(goal - position);
      scale = ISTEP_Q24;
      integral = clamp_acc(integral + (dist_err * scale) / Q24_ONE);
      goal = ang_goal;
      ang_err = clamp_acc(goal - heading);

      fwd = (gain_product(dist_kp, dist_err)
             + gain_product(dist_kd, dist_err - last_dist_err)
             + gain_product(dist_ki, integral)) / Q24_ONE;
      rot = (gain_product(angle_kp, ang_err)
             + gain_product(angle_kd, ang_err - last_angle_err)) / Q24_ONE;
      last_dist_err  = dist_err;
      last_angle_err = ang_err;

      res.left_drive  = DRIVE_W'(clamp_drive(fwd + rot));
      res.right_drive = DRIVE_W'(clamp_drive(fwd - rot));
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      drive_pair_type want;
      if (reset) begin
         dist_kp        = RST_DIST_PROP;
         dist_kd        = RST_DIST_DERIV;
         dist_ki        = RST_DIST_INTEG;
         angle_kp       = RST_ANGLE_PROP;
         angle_kd       = RST_ANGLE_DERIV;
         dist_scale     = RST_DIST_SCALE;
         angle_scale    = RST_ANGLE_SCALE;
         prev_left      = '0;
         prev_right     = '0;
         position       = 0;
         heading        = 0;
         integral       = 0;
         last_dist_err  = 0;
         last_angle_err = 0;
         drive_queue.delete();
      end else begin
         // Responses are matched before new requests are queued.
         if (rsp_valid && rsp_ready) begin
            if (drive_queue.size() == 0) begin
               $display("%0t: response with no tick pending, got left %0d right %0d",
                        $time, rsp_left_drive, rsp_right_drive);
               fail_count++;
            end else begin
               want = drive_queue.pop_front();
               ticks_checked++;
               if (rsp_left_drive !== want.left_drive) begin
                  $display("%0t: left_drive mismatch, expected %0d, got %0d",
                           $time, want.left_drive, rsp_left_drive);
                  fail_count++;
               end
               if (rsp_right_drive !== want.right_drive) begin
                  $display("%0t: right_drive mismatch, expected %0d, got %0d",
                           $time, want.right_drive, rsp_right_drive);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DIST_PROP:   dist_kp     = csr_wdata;
               CSR_DIST_DERIV:  dist_kd     = csr_wdata;
               CSR_DIST_INTEG:  dist_ki     = csr_wdata;
               CSR_ANGLE_PROP:  angle_kp    = csr_wdata;
               CSR_ANGLE_DERIV: angle_kd    = csr_wdata;
               CSR_DIST_SCALE:  dist_scale  = csr_wdata;
               CSR_ANGLE_SCALE: angle_scale = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            drive_queue.push_back(next_drive(req_left_count, req_right_count,
                                             req_target_position, req_target_angle));
         end
      end
      outstanding = drive_queue.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the differential-drive PID loop testbench: clock, reset, tick stimulus,
// register phases and the final verdict. Depends on ddpid_pkg, the block itself
// and ddpid_drive_checker, which predicts and compares every response.
module tb_top;
   import ddpid_pkg::*;

   // Share of cycles in which either side idles, in percent.
   localparam int IDLE_PCT     = 18;
   // Long receiver hold-off; far beyond the two ticks the block can buffer.
   localparam int HOLD_CYCLES  = 400;
   // Register settings after the reset defaults, and ticks sent under each.
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 55;
   // Phases that carry the special traffic patterns.
   localparam int HOLD_PHASE   = 3;
   localparam int QUIET_PHASE  = 4;
   localparam int PAUSE_PHASE  = 5;
   // Extra wait after the last response, before the final verdict.
   localparam int DRAIN_CYCLES = 60;
   // Timeout for the whole run, which is roughly 600 ticks plus stalls and gaps.
   localparam int TIME_LIMIT   = 4_000_000;
   // Index 7 decodes to no register; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [IN_COUNT_W-1:0]       req_left_count;
   logic [IN_COUNT_W-1:0]       req_right_count;
   logic signed [TARGET_W-1:0]  req_target_position;
   logic signed [TARGET_W-1:0]  req_target_angle;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [DRIVE_W-1:0]   rsp_left_drive;
   logic signed [DRIVE_W-1:0]   rsp_right_drive;
   logic                        csr_wr_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [GAIN_W-1:0]           csr_wdata;

   int fail_count;
   int outstanding;
   int ticks_checked;

   // Shared between the stimulus and the receiver process: quiet suppresses all
   // idling on both sides, hold_request asks the receiver for one long hold-off.
   bit quiet;
   bit hold_request;

   // Encoder readings last sent, and rough estimates of where the robot is, so
   // that most targets stay close enough for the PID terms not to saturate.
   logic [IN_COUNT_W-1:0] left_pos, right_pos;
   int fwd_est, turn_est;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   differential_drive_pid_loop dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_left_count      (req_left_count),
      .req_right_count     (req_right_count),
      .req_target_position (req_target_position),
      .req_target_angle    (req_target_angle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_drive      (rsp_left_drive),
      .rsp_right_drive     (rsp_right_drive),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   ddpid_drive_checker drive_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_left_count      (req_left_count),
      .req_right_count     (req_right_count),
      .req_target_position (req_target_position),
      .req_target_angle    (req_target_angle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_drive      (rsp_left_drive),
      .rsp_right_drive     (rsp_right_drive),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .ticks_checked       (ticks_checked)
   );

   // Offers one tick at the falling edge and holds it until the block takes
   // it at a rising edge. Afterwards the sender may idle at random with valid low;
   // without idling, valid simply stays high for the next tick.
   task automatic send_tick(input logic [IN_COUNT_W-1:0] left_raw,
                            input logic [IN_COUNT_W-1:0] right_raw,
                            input logic signed [TARGET_W-1:0] pos_goal,
                            input logic signed [TARGET_W-1:0] ang_goal);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_left_count      <= left_raw;
      req_right_count     <= right_raw;
      req_target_position <= pos_goal;
      req_target_angle    <= ang_goal;
      left_pos  = left_raw;
      right_pos = right_raw;
      do @(posedge clock); while (!req_ready);
      while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Most ticks are plausible motion: small wheel steps and targets near the
   // estimated pose. Some take large steps that probe the wrap correction, and
   // the rest are fully random fields.
   task automatic send_random_tick();
      int kind, dl, dr;
      logic signed [TARGET_W-1:0] pos_goal, ang_goal;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         dl = int'($urandom_range(0, 400)) - 200;
         dr = int'($urandom_range(0, 400)) - 200;
         fwd_est  = fwd_est + (dl + dr) / 2;
         turn_est = turn_est + (dl - dr) / 2;
         pos_goal = (fwd_est <<< 16) + int'($urandom_range(0, 1 << 20)) - (1 << 19);
         ang_goal = (turn_est <<< 16) + int'($urandom_range(0, 1 << 18)) - (1 << 17);
         send_tick(left_pos + IN_COUNT_W'(dl), right_pos + IN_COUNT_W'(dr),
                   pos_goal, ang_goal);
      end else if (kind < 85) begin
         dl = int'($urandom_range(0, 131070)) - 65535;
         dr = int'($urandom_range(0, 131070)) - 65535;
         pos_goal = int'($urandom_range(0, 1 << 26)) - (1 << 25);
         ang_goal = int'($urandom_range(0, 1 << 24)) - (1 << 23);
         send_tick(left_pos + IN_COUNT_W'(dl), right_pos + IN_COUNT_W'(dr),
                   pos_goal, ang_goal);
      end else begin
         send_tick(IN_COUNT_W'($urandom), IN_COUNT_W'($urandom), $urandom, $urandom);
      end
   endtask

   // Drops valid and waits until every queued tick has been answered, which
   // leaves the block idle since each tick yields exactly one response.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [GAIN_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // The first phase drives every register to its maximum, the second to zero;
   // later phases mix the extremes, realistic gains up to 16.0 and full range.
   function automatic logic [GAIN_W-1:0] pick_setting(input int phase);
      int mode;
      if (phase == 0) return '1;
      if (phase == 1) return '0;
      mode = $urandom_range(0, 9);
      if (mode == 0) return '0;
      if (mode == 1) return '1;
      if (mode < 6) return GAIN_W'($urandom_range(0, 4096));
      return GAIN_W'($urandom);
   endfunction

   task automatic load_settings(input int phase);
      write_register(CSR_DIST_PROP,   pick_setting(phase));
      write_register(CSR_DIST_DERIV,  pick_setting(phase));
      write_register(CSR_DIST_INTEG,  pick_setting(phase));
      write_register(CSR_ANGLE_PROP,  pick_setting(phase));
      write_register(CSR_ANGLE_DERIV, pick_setting(phase));
      write_register(CSR_DIST_SCALE,  pick_setting(phase));
      write_register(CSR_ANGLE_SCALE, pick_setting(phase));
      if (phase == 1) begin
         write_register(CSR_UNMAPPED, '1);
      end
   endtask

   // Receiver: randomly lowers ready, except during the quiet stretch. On
   // request it holds ready low for the long hold-off so that the block fills
   // its output register, holds the next tick in its final step and refuses requests.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_left_count      = '0;
      req_right_count     = '0;
      req_target_position = '0;
      req_target_angle    = '0;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      quiet               = 1'b0;
      hold_request        = 1'b0;
      left_pos            = '0;
      right_pos           = '0;
      fwd_est             = 0;
      turn_est            = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset register values. The first tick is
      // measured against readings of zero, so a left reading of all ones is a
      // one-count step backwards across the wrap.
      send_tick(16'hFFFF, 16'h0001, 32'sd0, 32'sd0);
      send_tick(16'h0000, 16'h0000, 32'sd0, 32'sd0);
      // A step of exactly the wrap threshold is kept as it is, both ways.
      send_tick(16'd61440, 16'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_tick(16'h0000, 16'h0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
      // One count beyond the threshold is taken as a wrap, both ways.
      send_tick(16'd61441, 16'h0000, -32'sd1, -32'sd1);
      send_tick(16'h0000, 16'd61441, 32'sd0, 32'sd0);
      send_tick(16'h0000, 16'h0000, 32'sd0, 32'sd0);
      // Odd sums and differences check the truncation of the halving.
      send_tick(16'h7FFF, 16'h8000, 32'sd1, -32'sd1);
      send_tick(16'h8000, 16'h7FFF, 32'sd0, 32'sd0);
      send_tick(16'h8001, 16'h7FFF, 32'sd0, 32'sd0);
      send_tick(16'h8000, 16'h7FFF, 32'sd0, 32'sd0);
      send_tick(16'h8000, 16'h8001, 32'sd0, 32'sd0);
      // Large targets drive both outputs into saturation in each direction.
      send_tick(16'h8000, 16'h8001, 32'sh4000_0000, 32'sd0);
      send_tick(16'h8000, 16'h8001, -32'sh4000_0000, 32'sd0);
      send_tick(16'h8000, 16'h8001, 32'sd0, 32'sh4000_0000);
      send_tick(16'h8000, 16'h8001, 32'sd0, -32'sh4000_0000);
      send_tick(16'hFFFF, 16'hFFFF, 32'sh0001_0000, 32'shFFFF_0000);
      send_tick(16'h5555, 16'hAAAA, 32'sh5555_5555, 32'shAAAA_AAAA);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_drained();
         load_settings(phase);
         if (phase == QUIET_PHASE) begin
            quiet = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == HOLD_PHASE && n == 10) begin
               hold_request = 1'b1;
            end
            if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
               wait_until_drained();
            end
            send_random_tick();
         end
         quiet = 1'b0;
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d control ticks under the reset values and %0d register settings,",
               ticks_checked, PHASES);
      $display("with wrap, threshold, truncation, saturation and back-pressure cases.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(TIME_LIMIT);
      $display("%0t: timeout with %0d responses still outstanding", $time, outstanding);
      $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
design/ddpid_pkg.sv
design/differential_drive_pid_loop.sv
tb/ddpid_drive_checker.sv
tb/tb_top.sv
